>>> rtl/pcm_wavetable_sound_generator_defines.svh
// Assertion macros for the port-level checker of the PCM wavetable generator.
// No dependencies; the checker includes this header by its bare name.
`ifndef PCM_WAVETABLE_SOUND_GENERATOR_DEFINES_SVH
`define PCM_WAVETABLE_SOUND_GENERATOR_DEFINES_SVH

// Generic concurrent assertion on an explicit clock and active-low reset.
`define PCMWT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define PCMWT_ASSERT_CLK(lbl, prop, msg) \
  `PCMWT_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/pcmwt_pkg.sv
// Shared types and constants of the PCM wavetable sound generator.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package pcmwt_pkg;

  localparam int unsigned RamBytesDefault = 131072;
  localparam int unsigned ChannelCount    = 8;
  localparam int unsigned PosW            = 27;

  typedef logic [2:0] ch_idx_t;

  localparam ch_idx_t LastCh = 3'(ChannelCount - 1);

  // Kind of input beat, carried on the slave tuser.
  typedef enum logic [1:0] {
    MODE_REG  = 2'd0,
    MODE_RAM  = 2'd1,
    MODE_TICK = 2'd2
  } mode_e;

  // Register map, low 13 address bits. Bit 12 opens the banked RAM window.
  localparam logic [12:0] REG_ENV     = 13'h0000;
  localparam logic [12:0] REG_PAN     = 13'h0001;
  localparam logic [12:0] REG_STEP_LO = 13'h0002;
  localparam logic [12:0] REG_STEP_HI = 13'h0003;
  localparam logic [12:0] REG_LOOP_LO = 13'h0004;
  localparam logic [12:0] REG_LOOP_HI = 13'h0005;
  localparam logic [12:0] REG_START   = 13'h0006;
  localparam logic [12:0] REG_CTRL    = 13'h0007;
  localparam logic [12:0] REG_KEY     = 13'h0008;

  localparam logic [7:0] LoopMarker = 8'hFF;

  // How one channel's result is formed.
  typedef enum logic [1:0] {
    RES_OFF,    // chip or channel off: zero sample, position untouched
    RES_STUCK,  // loop point also holds loop data: zero sample, not fresh
    RES_PLAY    // normal sample, position advances by the step
  } res_kind_e;

  typedef struct packed {
    logic      clr_step;
    logic      item_write;
    logic      rd_cur;
    logic      rd_loop;
    logic      emit;
    ch_idx_t   ch;
    ch_idx_t   rd_ch;
    res_kind_e res_kind;
  } pcmwt_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic active;
    logic pcm_loop;
    logic out_free;
  } pcmwt_sts_t;

endpackage

>>> rtl/pcmwt_ctrl.sv
// Sequencer of the PCM wavetable generator: RAM clear pass, item intake, per-channel steps.
// Depends on pcmwt_pkg; drives the datapath through pcmwt_cmd_t.
module pcmwt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic [1:0]             mode_i,
  output logic                   s_axis_tready_o,
  output pcmwt_pkg::pcmwt_cmd_t  cmd_o,
  input  pcmwt_pkg::pcmwt_sts_t  sts_i
);
  import pcmwt_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_RELOAD = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;
  ch_idx_t    ch_q, ch_d;
  res_kind_e  res_q, res_d;

  always_comb begin
    state_d         = state_q;
    ch_d            = ch_q;
    res_d           = res_q;
    s_axis_tready_o = (state_q == ST_IDLE);
    cmd_o           = '0;
    cmd_o.ch        = ch_q;
    cmd_o.rd_ch     = ch_q;
    cmd_o.res_kind  = res_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.item_write = 1'b1;
          if (mode_i == MODE_TICK) begin
            cmd_o.rd_cur = 1'b1;
            state_d      = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!sts_i.active) begin
          res_d   = RES_OFF;
          state_d = ST_EMIT;
        end else if (sts_i.pcm_loop) begin
          cmd_o.rd_loop = 1'b1;
          state_d       = ST_RELOAD;
        end else begin
          res_d   = RES_PLAY;
          state_d = ST_EMIT;
        end
      end
      ST_RELOAD: begin
        res_d   = sts_i.pcm_loop ? RES_STUCK : RES_PLAY;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (ch_q == LastCh) begin
            ch_d    = '0;
            state_d = ST_IDLE;
          end else begin
            // Fetch the next channel's byte while this result is loaded.
            cmd_o.rd_ch  = ch_q + 3'd1;
            cmd_o.rd_cur = 1'b1;
            ch_d         = ch_q + 3'd1;
            state_d      = ST_CHECK;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ch_q    <= '0;
      res_q   <= RES_OFF;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      res_q   <= res_d;
    end
  end

endmodule

>>> rtl/pcmwt_datapath.sv
// Datapath of the PCM wavetable generator: wave RAM, channel registers, multiply, output beat.
// Depends on pcmwt_pkg; obeys pcmwt_cmd_t from the controller and reports pcmwt_sts_t.
module pcmwt_datapath #(
  parameter int unsigned RamBytes = pcmwt_pkg::RamBytesDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic [31:0]            s_axis_tdata_i,
  input  logic [1:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [23:0]            m_axis_tdata_o,
  output logic [3:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o,
  input  pcmwt_pkg::pcmwt_cmd_t  cmd_i,
  output pcmwt_pkg::pcmwt_sts_t  sts_o
);
  import pcmwt_pkg::*;

  localparam int unsigned AddrW   = $clog2(RamBytes);
  localparam logic [17:0] RamSize = 18'(RamBytes);

  // Wave RAM: one write port, one registered read port.
  logic [7:0]       mem [RamBytes];
  logic [7:0]       rdata_q;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata;
  logic [AddrW-1:0] clr_addr_q;

  logic          large_q;
  logic          sounding_q;
  ch_idx_t       sel_ch_q;
  logic [3:0]    bank_q;
  logic [PosW-1:0] pos_q   [ChannelCount];
  logic [15:0]     step_q  [ChannelCount];
  logic [15:0]     loop_q  [ChannelCount];
  logic [7:0]      start_q [ChannelCount];
  logic [7:0]      env_q   [ChannelCount];
  logic [7:0]      pan_q   [ChannelCount];
  logic [ChannelCount-1:0] en_q;
  logic [PosW-1:0] cur_pos_q;
  logic [PosW-1:0] start_pos [ChannelCount];

  logic [1:0]  mode;
  logic [16:0] addr;
  logic [12:0] reg_addr;
  logic [7:0]  wbyte;
  logic        in_range;
  logic        reg_we;

  logic [PosW-1:0] pos_rd, loop_pos, next_pos;
  logic [16:0]     pos_word;
  logic [14:0]     mag;
  logic [15:0]     mag16, sample;

  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic [3:0]  out_user_q;
  logic        out_last_q;

  assign mode     = s_axis_tuser_i;
  assign addr     = s_axis_tdata_i[16:0];
  assign wbyte    = s_axis_tdata_i[24:17];
  assign reg_addr = addr[12:0];
  assign in_range = large_q ? ({1'b0, addr} < RamSize) : !addr[16];
  assign reg_we   = cmd_i.item_write && (mode == MODE_REG) && !reg_addr[12];

  // Write port arbitration: clear pass or an accepted write beat.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.item_write) begin
      unique case (mode)
        MODE_RAM: begin
          ram_we    = in_range;
          ram_waddr = addr[AddrW-1:0];
          ram_wdata = wbyte;
        end
        MODE_REG: begin
          ram_we    = reg_addr[12];
          ram_waddr = AddrW'({bank_q, reg_addr[11:0]});
          ram_wdata = wbyte;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // Read address: current play position, or the loop point on a reload.
  assign pos_rd    = pos_q[cmd_i.rd_ch];
  assign pos_word  = large_q ? pos_rd[26:10] : {1'b0, pos_rd[26:11]};
  assign ram_re    = cmd_i.rd_cur || cmd_i.rd_loop;
  assign ram_raddr = cmd_i.rd_loop ? AddrW'(loop_q[cmd_i.ch]) : pos_word[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      mem[ram_waddr] <= ram_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rdata_q <= mem[ram_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_q <= 1'b0;
    end else if (cfg_we_i) begin
      large_q <= cfg_wdata_i;
    end
  end

  assign loop_pos = large_q ? {1'b0, loop_q[cmd_i.ch], 10'b0} : {loop_q[cmd_i.ch], 11'b0};

  always_comb begin
    for (int i = 0; i < ChannelCount; i++) begin
      start_pos[i] = large_q ? {1'b0, start_q[i], 18'b0} : {start_q[i], 19'b0};
    end
  end

  assign next_pos = (cmd_i.res_kind == RES_PLAY) ?
                    cur_pos_q + PosW'(step_q[cmd_i.ch]) : cur_pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_loop) begin
      cur_pos_q <= loop_pos;
    end else if (cmd_i.rd_cur) begin
      cur_pos_q <= pos_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sounding_q <= 1'b0;
      sel_ch_q   <= '0;
      bank_q     <= '0;
      en_q       <= '0;
      for (int i = 0; i < ChannelCount; i++) begin
        pos_q[i]   <= '0;
        step_q[i]  <= '0;
        loop_q[i]  <= '0;
        start_q[i] <= '0;
        env_q[i]   <= '0;
        pan_q[i]   <= '0;
      end
    end else begin
      if (reg_we) begin
        unique case (reg_addr)
          REG_ENV:     env_q[sel_ch_q]        <= wbyte;
          REG_PAN:     pan_q[sel_ch_q]        <= wbyte;
          REG_STEP_LO: step_q[sel_ch_q][7:0]  <= wbyte;
          REG_STEP_HI: step_q[sel_ch_q][15:8] <= wbyte;
          REG_LOOP_LO: loop_q[sel_ch_q][7:0]  <= wbyte;
          REG_LOOP_HI: loop_q[sel_ch_q][15:8] <= wbyte;
          REG_START:   start_q[sel_ch_q]      <= wbyte;
          REG_CTRL: begin
            sounding_q <= wbyte[7];
            if (wbyte[6]) begin
              sel_ch_q <= wbyte[2:0];
            end else begin
              bank_q <= wbyte[3:0];
            end
          end
          REG_KEY: begin
            // Enables are active low; a channel switching on restarts at its start point.
            for (int i = 0; i < ChannelCount; i++) begin
              if (!wbyte[i] && !en_q[i]) begin
                pos_q[i] <= start_pos[i];
              end
            end
            en_q <= ~wbyte;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.emit && (cmd_i.res_kind != RES_OFF)) begin
        pos_q[cmd_i.ch] <= next_pos;
      end
    end
  end

  assign mag    = {8'b0, rdata_q[6:0]} * {7'b0, env_q[cmd_i.ch]};
  assign mag16  = {1'b0, mag};
  assign sample = (cmd_i.res_kind != RES_PLAY) ? 16'd0 :
                  (rdata_q[7] ? mag16 : (16'd0 - mag16));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {pan_q[cmd_i.ch][7:4], pan_q[cmd_i.ch][3:0], sample};
      out_user_q <= {(cmd_i.res_kind != RES_STUCK), cmd_i.ch};
      out_last_q <= (cmd_i.ch == LastCh);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  assign sts_o.clr_done = &clr_addr_q;
  assign sts_o.active   = sounding_q && en_q[cmd_i.ch];
  assign sts_o.pcm_loop = (rdata_q == LoopMarker);
  assign sts_o.out_free = !out_valid_q || m_axis_tready_i;

endmodule

>>> rtl/pcm_wavetable_sound_generator.sv
// Top level of the eight-channel PCM wavetable sound generator.
// Depends on pcmwt_pkg, pcmwt_ctrl and pcmwt_datapath.
//
// Usage: the slave stream carries one beat per command. tuser holds the mode: a
// register write, a direct wave RAM write, or a sample tick. Writes take effect at
// the accepting edge and return nothing. A tick returns eight master beats, one per
// channel in order 0 to 7, with tlast on channel 7. The large_ram register is
// written through cfg_we_i/cfg_wdata_i and should only change while idle.
// Sequencing: after a tick is accepted, each channel passes through a check state and an
// emit state, with a reload state between them when its byte is loop data and the loop
// point must be re-read through the single wave RAM read port. The emit state waits
// while the output register is full and the receiver is not ready. A write leaves the
// block idle, so the next command can follow it at once.
// A new command is taken once the last beat of a tick sits in the output register,
// even if the receiver has not yet taken it.
// Reset: control state clears at once; then a clearing pass writes zero to every
// wave RAM byte, one per cycle, with s_axis_tready_o low.
// Stalls: when m_axis_tready_i is low, the result beat holds and the channel
// sequencer waits; no result is dropped.
module pcm_wavetable_sound_generator #(
  parameter int unsigned RAM_BYTES = pcmwt_pkg::RamBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: bit 0 is large_ram.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Command stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [16:0] address, [24:17] data, rest zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] sample, [19:16] pan_left, [23:20] pan_right
  output logic [3:0]  m_axis_tuser_o,   // [2:0] channel, [3] fresh
  output logic        m_axis_tlast_o    // last channel of a tick
);
  import pcmwt_pkg::*;

  pcmwt_cmd_t cmd;
  pcmwt_sts_t sts;

  // The controller walks the channels; the datapath owns the channel state and the RAM.
  pcmwt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .mode_i          (s_axis_tuser_i),
    .s_axis_tready_o (s_axis_tready_o),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  pcmwt_datapath #(
    .RamBytes (RAM_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

>>> rtl/pcmwt_checker.sv
// Port-level checker for the PCM wavetable sound generator, bound to the top level.
// Depends on pcmwt_pkg and pcm_wavetable_sound_generator_defines.svh.
`include "pcm_wavetable_sound_generator_defines.svh"

module pcmwt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import pcmwt_pkg::*;

  // The frame marker belongs to the final channel only.
  `PCMWT_ASSERT_CLK(a_last_on_final_channel, m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[2:0] == LastCh, "tlast on a channel other than the last")

  // A channel stuck on loop data must be silent.
  `PCMWT_ASSERT_CLK(a_stuck_is_silent, m_axis_tvalid_o && !m_axis_tuser_o[3] |-> m_axis_tdata_o[15:0] == 16'd0, "non-fresh beat carries a nonzero sample")

  // A tick occupies the block: no command is taken on the next cycle.
  `PCMWT_ASSERT_CLK(a_tick_makes_busy, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == MODE_TICK |=> !s_axis_tready_o, "command taken right after a tick")

  // A stalled result beat holds.
  `PCMWT_ASSERT_CLK(a_beat_holds, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result beat changed")

endmodule

bind pcm_wavetable_sound_generator pcmwt_checker u_pcmwt_checker (.*);

>>> verif/pcmwt_sample_checker.sv
`timescale 1ns / 100ps
// Result checker for the PCM wavetable sound generator: it keeps its own copy of the
// wave RAM and channel state, predicts the eight beats of every tick and compares.
// Depends on pcmwt_pkg; watches the configuration port and both streams.
module pcmwt_sample_checker #(
  parameter int unsigned RAM_BYTES = pcmwt_pkg::RamBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // [16:0] address, [24:17] data
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,   // [15:0] sample, [19:16] pan_left, [23:20] pan_right
  input  logic [3:0]  m_axis_tuser_i,   // [2:0] channel, [3] fresh
  input  logic        m_axis_tlast_i,
  output int          pending_o,
  output int          mismatches_o
);
  import pcmwt_pkg::*;

  typedef bit [PosW-1:0] play_pos_t;

  typedef struct packed {
    logic [2:0]  ch;
    logic [15:0] sample;
    logic        fresh;
    logic [3:0]  pan_left;
    logic [3:0]  pan_right;
    logic        last;
  } sample_beat_t;

  bit [7:0]  wave_mem   [RAM_BYTES];
  play_pos_t play_pos   [ChannelCount];
  bit [15:0] step_size  [ChannelCount];
  bit [15:0] loop_addr  [ChannelCount];
  bit [15:0] start_word [ChannelCount];
  bit [7:0]  envelope   [ChannelCount];
  bit [7:0]  pan        [ChannelCount];
  bit        key_on     [ChannelCount];
  bit        sounding;
  bit [2:0]  sel_ch;
  bit [3:0]  sel_bank;
  bit        large_ram;

  sample_beat_t expected_beats[$];

  function automatic int unsigned pos_shift();
    return large_ram ? 10 : 11;
  endfunction

  function automatic bit [7:0] wave_at(play_pos_t p);
    return wave_mem[(p >> pos_shift()) % RAM_BYTES];
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic apply_register_write(bit [12:0] a, bit [7:0] v);
    bit [2:0] ch;
    ch = sel_ch;
    if (a[12]) begin
      // Banked window into the wave RAM.
      wave_mem[{sel_bank, a[11:0]} % RAM_BYTES] = v;
    end else begin
      case (a)
        REG_ENV:     envelope[ch] = v;
        REG_PAN:     pan[ch] = v;
        REG_STEP_LO: step_size[ch][7:0] = v;
        REG_STEP_HI: step_size[ch][15:8] = v;
        REG_LOOP_LO: loop_addr[ch][7:0] = v;
        REG_LOOP_HI: loop_addr[ch][15:8] = v;
        REG_START:   start_word[ch] = {v, 8'h00};
        REG_CTRL: begin
          sounding = v[7];
          if (v[6]) sel_ch = v[2:0];
          else sel_bank = v[3:0];
        end
        REG_KEY: begin
          // Enables are active low; a channel that turns on restarts at its start point.
          for (int i = 0; i < ChannelCount; i++) begin
            if (!v[i] && !key_on[i]) play_pos[i] = play_pos_t'(start_word[i]) << pos_shift();
            key_on[i] = !v[i];
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic play_tick();
    bit [7:0]     pcm;
    bit           ok;
    bit           fresh;
    int           mag;
    int           level;
    sample_beat_t b;
    for (int i = 0; i < ChannelCount; i++) begin
      level = 0;
      fresh = 1'b1;
      if (sounding && key_on[i]) begin
        pcm = wave_at(play_pos[i]);
        ok  = 1'b1;
        if (pcm == LoopMarker) begin
          play_pos[i] = play_pos_t'(loop_addr[i]) << pos_shift();
          pcm = wave_at(play_pos[i]);
          if (pcm == LoopMarker) begin
            ok    = 1'b0;
            fresh = 1'b0;
          end
        end
        if (ok) begin
          mag = int'(pcm[6:0]) * int'(envelope[i]);
          play_pos[i] = play_pos[i] + play_pos_t'(step_size[i]);
          level = pcm[7] ? mag : -mag;
        end
      end
      b.ch        = 3'(i);
      b.sample    = 16'(level);
      b.fresh     = fresh;
      b.pan_left  = pan[i][3:0];
      b.pan_right = pan[i][7:4];
      b.last      = (3'(i) == LastCh);
      expected_beats.push_back(b);
    end
  endtask

  task automatic apply_command(bit [1:0] mode, bit [16:0] addr, bit [7:0] v);
    int unsigned active_bytes;
    active_bytes = large_ram ? 131072 : 65536;
    if (active_bytes > RAM_BYTES) active_bytes = RAM_BYTES;
    case (mode)
      MODE_REG:  apply_register_write(addr[12:0], v);
      MODE_RAM:  if (addr < active_bytes) wave_mem[addr % RAM_BYTES] = v;
      MODE_TICK: play_tick();
      default: ;
    endcase
  endtask

  task automatic check_result(sample_beat_t got);
    sample_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("result beat arrived with none expected");
    end else begin
      want = expected_beats.pop_front();
      if (got !== want)
        report_mismatch($sformatf(
          "ch %0d sample %0d fresh %b pan %h/%h last %b, want %0d %0d %b %h/%h %b",
          got.ch, $signed(got.sample), got.fresh, got.pan_left, got.pan_right, got.last,
          want.ch, $signed(want.sample), want.fresh, want.pan_left, want.pan_right, want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) large_ram = cfg_wdata_i;
      if (m_axis_tvalid_i && m_axis_tready_i)
        check_result(sample_beat_t'({m_axis_tuser_i[2:0], m_axis_tdata_i[15:0], m_axis_tuser_i[3],
                                     m_axis_tdata_i[19:16], m_axis_tdata_i[23:20], m_axis_tlast_i}));
      if (s_axis_tvalid_i && s_axis_tready_i)
        apply_command(s_axis_tuser_i, s_axis_tdata_i[16:0], s_axis_tdata_i[24:17]);
      pending_o = expected_beats.size();
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the PCM wavetable sound generator: clock, reset, command stimulus
// and the final verdict. Depends on pcmwt_pkg, the block and pcmwt_sample_checker.
module tb_top;
  import pcmwt_pkg::*;

  localparam int unsigned RamBytes     = RamBytesDefault;
  // The limit covers the clearing pass after reset, which clears all RamBytes bytes, and
  // the rest of the run, with a wide margin.
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned PhaseBeats   = 68;
  // Room after the last expected beat for the block to finish a tick or write in flight.
  localparam int unsigned SettleCycles = 40;
  localparam logic [1:0]  ModeUnused   = 2'd3;
  localparam logic [7:0]  CtrlSound    = 8'h80;
  localparam logic [7:0]  CtrlSelect   = 8'h40;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          expected_pending;
  int          mismatches;
  int unsigned cycle_count;
  int unsigned phase_beats;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  pcm_wavetable_sound_generator #(
    .RAM_BYTES(RamBytes)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  pcmwt_sample_checker #(
    .RAM_BYTES(RamBytes)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .pending_o       (expected_pending),
    .mismatches_o    (mismatches)
  );

  // A 20 ns clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: if the run has not finished by the cycle limit, something is hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // The receiver stalls at random with the rate of the current phase. With a rate of
  // zero it is always ready.
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Present one command beat and hold it until the block takes it. The sender may idle
  // first; the beat is accepted at the edge where this task returns.
  task automatic send_beat(input logic [1:0] mode, input logic [16:0] addr,
                           input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, data, addr};
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Register writes only decode the low 13 address bits, so the upper four are random.
  task automatic put_register(input logic [12:0] reg_addr, input logic [7:0] data);
    send_beat(MODE_REG, {4'($urandom), reg_addr}, data);
  endtask

  function automatic logic [7:0] small_or_any(int unsigned hi);
    return ($urandom_range(99) < 85) ? 8'($urandom_range(hi)) : 8'($urandom);
  endfunction

  // Wave bytes carry loop data often enough that loops and stuck channels show up.
  function automatic logic [7:0] wave_byte();
    return ($urandom_range(4) == 0) ? LoopMarker : 8'($urandom);
  endfunction

  // Wait until every expected beat has come back, then give the block time to finish
  // any write still in flight before the configuration may change.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (expected_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One random command or short sequence. Most of the traffic keeps the channels'
  // start and loop points in the first kilobyte and writes wave bytes right there, so
  // that ticks read real data, hit loop data and get stuck now and then.
  task automatic random_command();
    logic [2:0] ch;
    logic [7:0] key;
    logic [7:0] data;
    logic [12:0] reg_addr;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 32) begin
      send_beat(MODE_TICK, 17'($urandom), 8'($urandom));
      phase_beats++;
    end else if (pick < 50) begin
      if ($urandom_range(9) < 7)
        send_beat(MODE_RAM, {7'd0, 2'($urandom), 8'($urandom_range(31))}, wave_byte());
      else
        send_beat(MODE_RAM, 17'($urandom_range(1023)), wave_byte());
      phase_beats++;
    end else if (pick < 70) begin
      if ($urandom_range(1) == 1) begin
        put_register(REG_CTRL, (($urandom_range(9) == 0) ? 8'h00 : CtrlSound) | CtrlSelect |
                               8'($urandom_range(7)));
        phase_beats++;
      end
      reg_addr = 13'($urandom_range(6));
      case (reg_addr)
        REG_STEP_HI:          data = small_or_any(4);
        REG_LOOP_LO:          data = small_or_any(31);
        REG_LOOP_HI, REG_START: data = small_or_any(3);
        default:              data = 8'($urandom);
      endcase
      put_register(reg_addr, data);
      phase_beats++;
    end else if (pick < 78) begin
      // Enables are active low; the AND of two random bytes keeps most channels on.
      put_register(REG_KEY, ($urandom_range(9) == 0) ? 8'hFF : (8'($urandom) & 8'($urandom)));
      phase_beats++;
    end else if (pick < 86) begin
      // Wave RAM written through the banked register window.
      put_register(REG_CTRL,
                   CtrlSound | (($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(15))));
      put_register({1'b1, ($urandom_range(1) == 1) ? 12'($urandom_range(1023)) : 12'($urandom)},
                   wave_byte());
      phase_beats += 2;
    end else if (pick < 88) begin
      // A channel restarted near the top of the address space with the largest step, so
      // that its position wraps around within a handful of ticks in the small RAM mode.
      ch = 3'($urandom);
      key = 8'($urandom) & 8'($urandom);
      put_register(REG_CTRL, CtrlSound | CtrlSelect | 8'(ch));
      put_register(REG_START, 8'hFF);
      put_register(REG_STEP_LO, 8'hFF);
      put_register(REG_STEP_HI, 8'hFF);
      put_register(REG_KEY, key | (8'h01 << ch));
      put_register(REG_KEY, key & ~(8'h01 << ch));
      repeat (10) send_beat(MODE_TICK, 17'($urandom), 8'($urandom));
      phase_beats += 16;
    end else begin
      // Noise: the unused mode, unused register addresses, RAM writes past the small
      // RAM size and wholly random beats. The first two are ignored and not counted.
      case ($urandom_range(3))
        0: send_beat(ModeUnused, 17'($urandom), 8'($urandom));
        1: put_register(13'($urandom_range(12'hFFF, 9)), 8'($urandom));
        2: begin
          send_beat(MODE_RAM, 17'($urandom_range(131071, 65536)), 8'($urandom));
          phase_beats++;
        end
        default: begin
          send_beat(2'($urandom), 17'($urandom), 8'($urandom));
          phase_beats++;
        end
      endcase
    end
  endtask

  initial begin
    // Every input is known from time zero; reset is asserted first and then released.
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    rst_n         <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the small RAM setting left from reset. Channel 0 is set up to
    // play from 0x100 with one byte per tick and to loop back to 0x180.
    put_register(REG_CTRL, CtrlSound | CtrlSelect);
    put_register(REG_ENV, 8'hFF);
    put_register(REG_PAN, 8'hA5);
    put_register(REG_STEP_LO, 8'h00);
    put_register(REG_STEP_HI, 8'h08);
    put_register(REG_START, 8'h01);
    put_register(REG_LOOP_LO, 8'h80);
    put_register(REG_LOOP_HI, 8'h01);
    // Largest positive byte, largest negative byte, loop data, then a positive zero.
    send_beat(MODE_RAM, 17'h00100, 8'hFE);
    send_beat(MODE_RAM, 17'h00101, 8'h7F);
    send_beat(MODE_RAM, 17'h00102, LoopMarker);
    send_beat(MODE_RAM, 17'h00180, 8'h80);
    // Switching channel 0 on loads its start point.
    put_register(REG_KEY, 8'hFE);
    repeat (4) send_beat(MODE_TICK, 17'h00000, 8'h00);
    // Channel 0 now sits at 0x182. Loop data goes there through the bank 0 window and
    // the loop point moves onto loop data too, so the next tick finds it stuck.
    put_register(REG_CTRL, CtrlSound);
    put_register(13'h1182, LoopMarker);
    put_register(REG_LOOP_LO, 8'h02);
    send_beat(MODE_TICK, 17'h1FFFF, 8'hFF);
    // The unused mode, an unused register address and a RAM write past the small RAM.
    send_beat(ModeUnused, 17'h1FFFF, 8'hFF);
    send_beat(MODE_REG, 17'h1E009, 8'h00);
    send_beat(MODE_RAM, 17'h1FFFF, 8'h55);
    send_beat(MODE_TICK, 17'h00000, 8'h00);

    // Random part in four phases, alternating the RAM size and varying the idling pattern.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= (phase % 2 == 0);
      @(posedge clk);
      cfg_we <= 1'b0;
      phase_beats = 0;
      while (phase_beats < PhaseBeats) random_command();
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
